### rtl/oaht_pkg.sv
// Shared types and constants for the open addressing hash table.
`default_nettype none
package oaht_pkg;
	localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
	localparam logic [31:0] FNV_MUL = 32'h01000193;

	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic [2:0] ST_HIT = 3'd0;
	localparam logic [2:0] ST_NEW = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_ZERO = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	localparam logic [1:0] TAG_EMPTY = 2'd0;
	localparam logic [1:0] TAG_USED = 2'd1;
	localparam logic [1:0] TAG_TOMB = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH, S_HMUL, S_RD, S_WAIT, S_CHK, S_WR, S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic hash_xor;
		logic hash_mul;
		logic probe_init;
		logic rd;
		logic probe_next;
		logic clr_next;
		logic commit;
		logic report;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic hash_last;
		logic is_zero;
		logic is_bad;
		logic found;
		logic probe_last;
	} sts_t;
endpackage
`default_nettype wire

### rtl/oaht_ctrl.sv
// Controller state machine: clearing pass, hashing, probing and write back.
`default_nettype none
module oaht_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire oaht_pkg::sts_t sts,
	output logic busy,
	output oaht_pkg::cmd_t cmd
);
	import oaht_pkg::*;

	state_t state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= nxt;
	end

	always_comb begin
		nxt = state_q;
		unique case (state_q)
			S_CLEAR: if (sts.clr_last) nxt = S_IDLE;
			S_IDLE: if (start) nxt = S_HASH;
			S_HASH: begin
				if (sts.is_zero || sts.is_bad) nxt = S_DONE;
				else if (sts.hash_last) nxt = S_RD;
				else nxt = S_HMUL;
			end
			S_HMUL: nxt = S_HASH;
			S_RD: nxt = S_WAIT;
			S_WAIT: nxt = S_CHK;
			S_CHK: begin
				if (sts.found || sts.probe_last) nxt = S_WR;
				else nxt = S_RD;
			end
			S_WR: nxt = S_DONE;
			S_DONE: nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			S_CLEAR: cmd.clr_next = 1'b1;
			S_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			S_HASH: begin
				cmd.hash_xor = 1'b1;
				cmd.probe_init = sts.hash_last;
			end
			S_HMUL: cmd.hash_mul = 1'b1;
			S_RD: cmd.rd = 1'b1;
			S_WAIT: ;
			S_CHK: cmd.probe_next = !(sts.found || sts.probe_last);
			S_WR: cmd.commit = 1'b1;
			S_DONE: cmd.report = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### rtl/oaht_dp.sv
// Datapath: FNV-1a hash, slot memories, probe walk and result registers.
`default_nettype none
module oaht_dp #(
	parameter int CAPACITY = 1024,
	parameter int KEY_BYTES = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire oaht_pkg::cmd_t cmd,
	output oaht_pkg::sts_t sts,
	input wire logic fill_we,
	input wire logic [9:0] fill_data,
	input wire logic [1:0] kind,
	input wire logic [63:0] key,
	input wire logic [3:0] key_len,
	input wire logic [31:0] value,
	output logic done,
	output logic [2:0] status,
	output logic [31:0] value_out,
	output logic [9:0] key_count
);
	import oaht_pkg::*;

	localparam int IW = $clog2(CAPACITY);

	logic [1:0] tag_mem [CAPACITY];
	logic [63:0] key_mem [CAPACITY];
	logic [3:0] len_mem [CAPACITY];
	logic [31:0] hash_mem [CAPACITY];
	logic [31:0] val_mem [CAPACITY];

	logic [9:0] fill_q, count_q;
	logic [1:0] kind_q;
	logic [63:0] key_q, shift_q;
	logic [3:0] len_q, step_q;
	logic [31:0] val_q, hash_q;
	logic [IW-1:0] idx_q, clr_q, tomb_q;
	logic [IW:0] visits_q;
	logic have_tomb_q, have_empty_q, hit_q;
	logic [1:0] rtag_q;
	logic [63:0] rkey_q;
	logic [3:0] rlen_q;
	logic [31:0] rhash_q, rval_q;
	logic [2:0] status_q;
	logic [31:0] vout_q;
	logic done_q;

	logic [3:0] len_c;
	logic [63:0] key_c;
	logic match_c, empty_c;
	logic [IW-1:0] dest_c;

	logic rtag_chk;
	logic chk_end;
	logic chk_q;
	logic rd_s1;

	always_comb begin
		len_c = (key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_len;
		key_c = key;
		for (int i = 0; i < 8; i++)
			if (4'(i) >= len_c) key_c[8*i +: 8] = 8'h00;
	end

	assign empty_c = (rtag_q == TAG_EMPTY);
	assign match_c = (rtag_q == TAG_USED) && (rhash_q == hash_q) &&
		(rlen_q == len_q) && (rkey_q == key_q);
	assign dest_c = have_tomb_q ? tomb_q : idx_q;

	assign sts.clr_last = (clr_q == IW'(CAPACITY - 1));
	assign sts.hash_last = (step_q == len_q);
	assign sts.is_zero = (kind_q == KIND_INSERT) && (val_q == 32'd0);
	assign sts.is_bad = (kind_q == KIND_NONE);
	assign sts.found = empty_c || match_c;
	assign sts.probe_last = (visits_q == (IW+1)'(CAPACITY - 1));

	// memory ports
	always_ff @(posedge clk) begin
		if (cmd.clr_next) tag_mem[clr_q] <= TAG_EMPTY;
		if (cmd.rd) begin
			rtag_q <= tag_mem[idx_q];
			rkey_q <= key_mem[idx_q];
			rlen_q <= len_mem[idx_q];
			rhash_q <= hash_mem[idx_q];
			rval_q <= val_mem[idx_q];
		end
		if (cmd.commit) begin
			if (kind_q == KIND_REMOVE && hit_q) tag_mem[idx_q] <= TAG_TOMB;
			if (kind_q == KIND_INSERT && hit_q) val_mem[idx_q] <= val_q;
			if (kind_q == KIND_INSERT && !hit_q && count_q < fill_q &&
				(have_tomb_q || have_empty_q)) begin
				tag_mem[dest_c] <= TAG_USED;
				key_mem[dest_c] <= key_q;
				len_mem[dest_c] <= len_q;
				hash_mem[dest_c] <= hash_q;
				val_mem[dest_c] <= val_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			key_q <= key_c;
			shift_q <= key_c;
			len_q <= len_c;
			val_q <= value;
			hash_q <= FNV_BASIS;
			step_q <= 4'd0;
		end
		if (cmd.hash_xor && !sts.hash_last) begin
			hash_q <= hash_q ^ {24'd0, shift_q[7:0]};
			shift_q <= shift_q >> 8;
			step_q <= step_q + 4'd1;
		end
		if (cmd.hash_mul) hash_q <= hash_q * FNV_MUL;
		if (cmd.probe_init) begin
			idx_q <= hash_q[IW-1:0];
			visits_q <= '0;
			have_tomb_q <= 1'b0;
			have_empty_q <= 1'b0;
			hit_q <= 1'b0;
		end
		// record the outcome of the slot just read
		if (rtag_chk) begin
			if (rtag_q == TAG_TOMB && !have_tomb_q) begin
				have_tomb_q <= 1'b1;
				tomb_q <= idx_q;
			end
			have_empty_q <= empty_c;
			hit_q <= match_c;
		end
		if (cmd.probe_next) begin
			idx_q <= idx_q + IW'(1);
			visits_q <= visits_q + (IW+1)'(1);
		end
	end

	assign rtag_chk = cmd.probe_next || chk_end;
	// a read is tracked through rd_s1 and then chk_q; the last check ends the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			chk_q <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
			chk_q <= rd_s1;
		end
	end
	assign chk_end = chk_q && !cmd.probe_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 10'd717;
			count_q <= '0;
			clr_q <= '0;
			done_q <= 1'b0;
			status_q <= ST_HIT;
			vout_q <= '0;
		end else begin
			done_q <= cmd.report;
			if (fill_we) fill_q <= fill_data;
			if (cmd.clr_next) clr_q <= clr_q + IW'(1);
			if (cmd.load) begin
				status_q <= ST_NOT_FOUND;
				vout_q <= '0;
			end
			if (cmd.hash_xor && sts.is_zero) status_q <= ST_ZERO;
			if (cmd.commit) begin
				if (hit_q) begin
					status_q <= ST_HIT;
					if (kind_q == KIND_LOOKUP) vout_q <= rval_q;
				end else if (kind_q == KIND_INSERT) begin
					if (count_q >= fill_q || !(have_tomb_q || have_empty_q))
						status_q <= ST_FULL;
					else begin
						status_q <= ST_NEW;
						count_q <= count_q + 10'd1;
					end
				end
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign value_out = vout_q;
	assign key_count = count_q;
endmodule
`default_nettype wire

### rtl/open_addressing_hash_table.sv
// Top level of the open addressing hash table.
// Sequence: the clamped key bytes are hashed, 1 to CAPACITY slots are probed, the write back
// follows and done is registered from the report state; a zero insert value or unused kind
// skips straight to the report. Throughput: one request at a time; start is taken again in
// the cycle done shows. Reset clears control at once, then a clearing pass empties the slot
// tags; busy stays high through it. The receiver cannot stall: done pulses for one cycle.
`default_nettype none
module open_addressing_hash_table #(
	parameter int CAPACITY = 1024,
	parameter int KEY_BYTES = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic cfg_we,
	input wire logic [9:0] cfg_data,
	input wire logic [1:0] kind,
	input wire logic [63:0] key,
	input wire logic [3:0] key_len,
	input wire logic [31:0] value,
	output logic done,
	output logic [2:0] status,
	output logic [31:0] value_out,
	output logic [9:0] key_count
);
	import oaht_pkg::*;

	cmd_t cmd;
	sts_t sts;

	oaht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
	);

	oaht_dp #(.CAPACITY(CAPACITY), .KEY_BYTES(KEY_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.fill_we(cfg_we), .fill_data(cfg_data),
		.kind(kind), .key(key), .key_len(key_len), .value(value),
		.done(done), .status(status), .value_out(value_out), .key_count(key_count)
	);
endmodule
`default_nettype wire

### rtl/oaht_checker.sv
// Port-level checker for the open addressing hash table.
`default_nettype none
module oaht_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [2:0] status,
	input wire logic [31:0] value_out,
	input wire logic [9:0] key_count
);
	import oaht_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= ST_FULL) else $error("bad status");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_NEW |-> $stable(key_count)) else $error("count moved");
	a_vout: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_HIT |-> value_out == 32'd0) else $error("value leak");
endmodule

bind open_addressing_hash_table oaht_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .value_out(value_out), .key_count(key_count)
);
`default_nettype wire
